// ----- rtl/tialu_pkg.sv -----
// Shared types, opcodes and status codes for the typed integer ALU.
`default_nettype none
package tialu_pkg;

  localparam int unsigned DataW   = 64;
  localparam int unsigned DivSteps = 4;            // quotient bits per divider stage
  localparam int unsigned DivStages = DataW / DivSteps;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,  OP_SUB = 4'd1,  OP_MUL = 4'd2,  OP_DIV = 4'd3,
    OP_REM  = 4'd4,  OP_AND = 4'd5,  OP_OR  = 4'd6,  OP_XOR = 4'd7,
    OP_SHL  = 4'd8,  OP_SHR = 4'd9,  OP_EQ  = 4'd10, OP_NE  = 4'd11,
    OP_GT   = 4'd12, OP_GE  = 4'd13, OP_CAST = 4'd14, OP_BAD = 4'd15
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DIV_ZERO = 3'd1,
    ST_DIV_OVF  = 3'd2,
    ST_UNSUP    = 3'd3,
    ST_SHIFT    = 3'd4
  } status_t;

  localparam logic [3:0] CastPtr = 4'd8;

  // Decoded request, registered at the end of stage 0.
  typedef struct packed {
    op_t              op;
    logic [1:0]       wsel;     // 0..3 -> 8/16/32/64 bits
    logic             sgn;
    logic [DataW-1:0] a;        // extended operands
    logic [DataW-1:0] b;
    logic [3:0]       ct;
  } req_t;

  // Divider working state between stages.
  typedef struct packed {
    logic [DataW-1:0] rem;
    logic [DataW-1:0] quo;      // dividend bits shifting out, quotient bits in
    logic [DataW-1:0] dvs;
    logic             neg_q;
    logic             neg_r;
  } div_t;

  function automatic logic [DataW-1:0] wmask(input logic [1:0] wsel);
    logic [DataW-1:0] m;
    unique case (wsel)
      2'd0:    m = 64'h0000_0000_0000_00FF;
      2'd1:    m = 64'h0000_0000_0000_FFFF;
      2'd2:    m = 64'h0000_0000_FFFF_FFFF;
      default: m = '1;
    endcase
    return m;
  endfunction

  function automatic logic [DataW-1:0] extend(input logic [DataW-1:0] x,
                                              input logic [1:0] wsel,
                                              input logic sgn);
    logic [DataW-1:0] y;
    y = x;
    unique case (wsel)
      2'd0:    y = {{56{sgn & x[7]}},  x[7:0]};
      2'd1:    y = {{48{sgn & x[15]}}, x[15:0]};
      2'd2:    y = {{32{sgn & x[31]}}, x[31:0]};
      default: y = x;
    endcase
    return y;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/tialu_div_stage.sv -----
// One divider stage: DivSteps restoring steps on the magnitudes.
`default_nettype none
module tialu_div_stage (
  input  wire tialu_pkg::div_t d_in,
  output tialu_pkg::div_t      d_out
);
  import tialu_pkg::*;

  always_comb begin
    logic [DataW:0]   trial;
    logic [DataW-1:0] rem;
    logic [DataW-1:0] quo;
    rem = d_in.rem;
    quo = d_in.quo;
    for (int i = 0; i < DivSteps; i++) begin
      trial = {rem, quo[DataW-1]} - {1'b0, d_in.dvs};
      if (!trial[DataW]) begin
        rem = trial[DataW-1:0];
        quo = {quo[DataW-2:0], 1'b1};
      end else begin
        rem = {rem[DataW-2:0], quo[DataW-1]};
        quo = {quo[DataW-2:0], 1'b0};
      end
    end
    d_out       = d_in;
    d_out.rem   = rem;
    d_out.quo   = quo;
  end
endmodule
`default_nettype wire

// ----- rtl/tialu_mul.sv -----
// 64x64 low-half multiplier: 32x32 partial products are registered, then summed.
`default_nettype none
module tialu_mul (
  input  wire               clk,
  input  wire               en,
  input  wire  [63:0]       a,
  input  wire  [63:0]       b,
  output logic [63:0]       p
);
  import tialu_pkg::*;

  logic [63:0] ll_r;
  logic [31:0] lh_r, hl_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= a[31:0] * b[31:0];
      lh_r <= 32'(a[31:0] * b[63:32]);
      hl_r <= 32'(a[63:32] * b[31:0]);
    end
  end

  assign p = ll_r + {lh_r + hl_r, 32'd0};
endmodule
`default_nettype wire

// ----- rtl/typed_integer_alu.sv -----
// Top level of the typed integer ALU pipeline.
`default_nettype none
// Typed integer ALU. One request per cycle while the output is not stalled,
// fully pipelined: requests on in_* pass decode, divider and output registers
// to out_*. Depth comes from the divider, a chain of sixteen stages that
// each retire four quotient bits; every other operation is computed in the
// first stages and travels alongside. A stall on out_tready holds the whole
// pipeline; in_tready is high whenever the output register is free or moves.
// Operands are taken at the width of operand_type and results are returned
// zero-extended; undefined C cases get a fixed result and a status code.
module typed_integer_alu (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  // [3:0] req_type, [6:4] operand_type, [70:7] operand_a, [134:71] operand_b,
  // [138:135] cast_target, [143:139] zero
  input  wire [143:0] in_tdata,
  output logic        out_tvalid,
  input  wire         out_tready,
  // [63:0] result_bits, [66:64] status, [71:67] zero
  output logic [71:0] out_tdata
);
  import tialu_pkg::*;

  localparam int unsigned NStg = DivStages + 3;   // decode, prep, div stages, final

  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // Stage 0: decode and extend
  req_t req_nxt, req_r;
  logic v0_r;
  always_comb begin
    logic [2:0] ty;
    ty            = in_tdata[6:4];
    req_nxt.op    = op_t'(in_tdata[3:0]);
    req_nxt.wsel  = ty[1:0];
    req_nxt.sgn   = !ty[2];
    req_nxt.a     = extend(in_tdata[70:7], ty[1:0], !ty[2]);
    req_nxt.b     = extend(in_tdata[134:71], ty[1:0], !ty[2]);
    req_nxt.ct    = in_tdata[138:135];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (adv) v0_r <= in_tvalid;
    if (adv) req_r <= req_nxt;
  end

  // Stage 1: everything but mul and div; divider operand prep
  logic [63:0] m;
  logic [63:0] r1_nxt;
  status_t     s1_nxt;
  logic        div_special;
  div_t        dprep;
  always_comb begin
    logic [63:0] smin, sh;
    logic        neg, na, nb;
    m     = wmask(req_r.wsel);
    smin  = extend(64'd1 << ((7'd8 << req_r.wsel) - 7'd1), req_r.wsel, 1'b1);
    sh    = req_r.b & m;
    neg   = req_r.a[63];
    r1_nxt = '0;
    s1_nxt = ST_OK;
    div_special = 1'b0;
    unique case (req_r.op)
      OP_ADD: r1_nxt = (req_r.a + req_r.b) & m;
      OP_SUB: r1_nxt = (req_r.a - req_r.b) & m;
      OP_MUL: r1_nxt = '0;
      OP_DIV, OP_REM: begin
        if (sh == '0) begin
          s1_nxt = ST_DIV_ZERO; div_special = 1'b1;
        end else if (req_r.sgn && req_r.a == smin && req_r.b == '1) begin
          s1_nxt = ST_DIV_OVF; div_special = 1'b1;
          r1_nxt = (req_r.op == OP_DIV) ? (smin & m) : '0;
        end
      end
      OP_AND: r1_nxt = req_r.a & req_r.b & m;
      OP_OR:  r1_nxt = (req_r.a | req_r.b) & m;
      OP_XOR: r1_nxt = (req_r.a ^ req_r.b) & m;
      OP_SHL, OP_SHR: begin
        if (sh >= 64'(7'd8 << req_r.wsel)) begin
          s1_nxt = ST_SHIFT;
          r1_nxt = (req_r.op == OP_SHR && req_r.sgn && neg) ? m : '0;
        end else if (req_r.op == OP_SHL) begin
          r1_nxt = (req_r.a << sh[5:0]) & m;
        end else if (req_r.sgn) begin
          r1_nxt = 64'($signed(req_r.a) >>> sh[5:0]) & m;
        end else begin
          r1_nxt = (req_r.a >> sh[5:0]) & m;
        end
      end
      OP_EQ: r1_nxt = {63'd0, req_r.a == req_r.b};
      OP_NE: r1_nxt = {63'd0, req_r.a != req_r.b};
      OP_GT: r1_nxt = {63'd0, (req_r.a ^ {req_r.sgn, 63'd0}) > (req_r.b ^ {req_r.sgn, 63'd0})};
      OP_GE: r1_nxt = {63'd0, (req_r.a ^ {req_r.sgn, 63'd0}) >= (req_r.b ^ {req_r.sgn, 63'd0})};
      OP_CAST: begin
        if (req_r.ct < CastPtr) r1_nxt = req_r.a & wmask(req_r.ct[1:0]);
        else if (req_r.ct == CastPtr) r1_nxt = {32'd0, req_r.a[31:0]};
        else s1_nxt = ST_UNSUP;
      end
      default: s1_nxt = ST_UNSUP;
    endcase
    na = req_r.sgn && req_r.a[63];
    nb = req_r.sgn && req_r.b[63];
    dprep.rem   = '0;
    dprep.quo   = na ? -req_r.a : req_r.a;
    dprep.dvs   = nb ? -req_r.b : req_r.b;
    dprep.neg_q = na ^ nb;
    dprep.neg_r = na;
  end

  // Side band that travels with the divider
  typedef struct packed {
    logic        v;
    op_t         op;
    logic [63:0] m;
    logic        use_div;
    logic        use_mul;
    logic [63:0] r;
    status_t     st;
  } side_t;

  side_t side_nxt;
  always_comb begin
    side_nxt.v       = v0_r;
    side_nxt.op      = req_r.op;
    side_nxt.m       = m;
    side_nxt.use_div = (req_r.op == OP_DIV || req_r.op == OP_REM) && !div_special;
    side_nxt.use_mul = req_r.op == OP_MUL;
    side_nxt.r       = r1_nxt;
    side_nxt.st      = s1_nxt;
  end

  side_t side_r [NStg-2];
  div_t  dv_r   [DivStages+1];
  div_t  dv_nxt [DivStages];
  logic [63:0] mul_p;
  side_t side1_nxt;

  tialu_mul u_mul (.clk(clk), .en(adv), .a(req_r.a), .b(req_r.b), .p(mul_p));

  for (genvar g = 0; g < DivStages; g++) begin : g_div
    tialu_div_stage u_stage (.d_in(dv_r[g]), .d_out(dv_nxt[g]));
  end

  // Merge the product into the side band once the multiplier has finished
  always_comb begin
    side1_nxt = side_r[0];
    if (side_r[0].use_mul) side1_nxt.r = mul_p & side_r[0].m;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NStg - 2; i++) side_r[i].v <= 1'b0;
    end else if (adv) begin
      side_r[0] <= side_nxt;
      side_r[1] <= side1_nxt;
      for (int i = 2; i < NStg - 2; i++) side_r[i] <= side_r[i-1];
    end
    if (adv) begin
      dv_r[0] <= dprep;
      for (int i = 0; i < DivStages; i++) dv_r[i+1] <= dv_nxt[i];
    end
  end

  // Final stage: pick divider result, sign-correct, register output
  logic [71:0] out_nxt;
  always_comb begin
    side_t       s;
    div_t        d;
    logic [63:0] q, rm, r;
    s  = side_r[NStg-3];
    d  = dv_r[DivStages];
    q  = d.neg_q ? -d.quo : d.quo;
    rm = d.neg_r ? -d.rem : d.rem;
    r  = s.r;
    if (s.use_div) r = ((s.op == OP_DIV) ? q : rm) & s.m;
    out_nxt = {5'd0, s.st, r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid <= 1'b0;
    else if (adv) out_tvalid <= side_r[NStg-3].v;
    if (adv) out_tdata <= out_nxt;
  end
endmodule
`default_nettype wire

// ----- rtl/typed_integer_alu_checker.sv -----
// Port-level checks for the typed integer ALU, bound to the top level.
`default_nettype none
module typed_integer_alu_checker (
  input wire         clk,
  input wire         rst_n,
  input wire         in_tready,
  input wire         out_tvalid,
  input wire         out_tready,
  input wire [71:0]  out_tdata
);
  import tialu_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[66:64] <= 3'(ST_SHIFT))
    else $error("status out of range");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("valid after reset");
endmodule

bind typed_integer_alu typed_integer_alu_checker u_chk (.*);
`default_nettype wire

// ----- dv/tialu_checker.sv -----
// Result checker for the typed integer ALU: predicts each request and compares results.
module tialu_checker (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  input  wire         in_tready,
  input  wire [143:0] in_tdata,
  input  wire         out_tvalid,
  input  wire         out_tready,
  input  wire [71:0]  out_tdata,
  output int          fail_count,
  output int          pending
);
  import tialu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [63:0] bits;
    status_t     st;
  } alu_result_t;

  alu_result_t expected_q[$];

  function automatic logic [63:0] mask_of(input int unsigned w);
    return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
  endfunction

  function automatic logic [63:0] widen(input logic [63:0] x, input int unsigned w,
                                        input bit sgn);
    logic [63:0] m;
    m = mask_of(w);
    x &= m;
    if (sgn && w < 64 && x[w-1]) x |= ~m;
    return x;
  endfunction

  function automatic alu_result_t compute_alu(input logic [143:0] d);
    alu_result_t res;
    op_t         op;
    logic [2:0]  ty;
    logic [3:0]  ct;
    int unsigned w;
    bit          sgn, na, nb;
    logic [63:0] m, a, b, smin, ma, mb, q, x, y;
    op  = op_t'(d[3:0]);
    ty  = d[6:4];
    ct  = d[138:135];
    w   = 8 << ty[1:0];
    sgn = (ty < 4);
    m   = mask_of(w);
    a   = widen(d[70:7], w, sgn);
    b   = widen(d[134:71], w, sgn);
    smin = widen(64'd1 << (w - 1), w, 1'b1);
    res.bits = '0;
    res.st = ST_OK;
    case (op)
      OP_ADD: res.bits = (a + b) & m;
      OP_SUB: res.bits = (a - b) & m;
      OP_MUL: res.bits = (a * b) & m;
      OP_DIV, OP_REM: begin
        if ((b & m) == 0) begin
          res.st = ST_DIV_ZERO;
        end else if (sgn && a == smin && b == '1) begin
          res.st = ST_DIV_OVF;
          res.bits = (op == OP_DIV) ? (smin & m) : '0;
        end else if (!sgn) begin
          res.bits = ((op == OP_DIV) ? a / b : a % b) & m;
        end else begin
          // work on magnitudes, then restore the sign
          na = a[63];
          nb = b[63];
          ma = na ? -a : a;
          mb = nb ? -b : b;
          if (op == OP_DIV) begin
            q = ma / mb;
            res.bits = ((na != nb) ? -q : q) & m;
          end else begin
            q = ma % mb;
            res.bits = (na ? -q : q) & m;
          end
        end
      end
      OP_AND: res.bits = a & b & m;
      OP_OR:  res.bits = (a | b) & m;
      OP_XOR: res.bits = (a ^ b) & m;
      OP_SHL, OP_SHR: begin
        if ((b & m) >= w) begin
          res.st = ST_SHIFT;
          res.bits = (op == OP_SHR && sgn && a[63]) ? m : '0;
        end else if (op == OP_SHL) begin
          res.bits = (a << (b & m)) & m;
        end else if (sgn && a[63]) begin
          // a is sign-extended, so shifting in ones is exact
          res.bits = (~((~a) >> (b & m))) & m;
        end else begin
          res.bits = (a >> (b & m)) & m;
        end
      end
      OP_EQ: res.bits = {63'd0, a == b};
      OP_NE: res.bits = {63'd0, a != b};
      OP_GT, OP_GE: begin
        x = sgn ? a ^ 64'h8000_0000_0000_0000 : a;
        y = sgn ? b ^ 64'h8000_0000_0000_0000 : b;
        res.bits = {63'd0, (op == OP_GT) ? x > y : x >= y};
      end
      OP_CAST: begin
        if (ct <= 7) res.bits = a & mask_of(8 << ct[1:0]);
        else if (ct == CastPtr) res.bits = a & 64'hFFFF_FFFF;
        else res.st = ST_UNSUP;
      end
      default: res.st = ST_UNSUP;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t checker: %s", $realtime, what);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    alu_result_t exp_r;
    if (rst_n) begin
      if (in_tvalid && in_tready) expected_q.push_back(compute_alu(in_tdata));
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", out_tdata));
        end else begin
          exp_r = expected_q.pop_front();
          if (out_tdata[63:0] !== exp_r.bits)
            report_mismatch($sformatf("result_bits %h, want %h", out_tdata[63:0], exp_r.bits));
          if (out_tdata[66:64] !== exp_r.st)
            report_mismatch($sformatf("status %0d, want %0d", out_tdata[66:64], exp_r.st));
          if (out_tdata[71:67] !== 5'd0)
            report_mismatch($sformatf("pad bits %b", out_tdata[71:67]));
        end
      end
    end
    pending = expected_q.size();
  end
endmodule

// ----- dv/tb.sv -----
// Testbench top for the typed integer ALU: stimulus, idling phases and verdict.
module tb;
  import tialu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  wire          in_tready;
  logic [143:0] in_tdata;   // req_type, operand_type, operand_a, operand_b, cast_target, pad
  wire          out_tvalid;
  logic         out_tready;
  wire  [71:0]  out_tdata;  // result_bits, status, pad
  int           fail_count;
  int           pending;
  int           sent;
  int           send_idle_pct;
  int           recv_stall_pct;

  typed_integer_alu u_top (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready, .out_tdata
  );

  tialu_checker u_chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready, .out_tdata,
    .fail_count, .pending
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #2ms;
    $display("tb: errors");
    $finish;
  end

  // Receiver: stall at the current rate.
  always @(posedge clk)
    out_tready <= ($urandom_range(99) >= recv_stall_pct);

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Pick an operand value that favors edges of the given width.
  function automatic logic [63:0] pick_operand(input logic [2:0] ty);
    int unsigned w;
    logic [63:0] v;
    w = 8 << ty[1:0];
    case ($urandom_range(7))
      0: v = 64'd0;
      1: v = '1;
      2: v = 64'd1 << (w - 1);
      3: v = (64'd1 << (w - 1)) - 1;
      4: v = 64'($urandom_range(w + 2));
      default: v = rand64();
    endcase
    // garbage above the width must be ignored
    if ($urandom_range(1)) v |= rand64() & ~((w >= 64) ? '1 : ((64'd1 << w) - 1));
    return v;
  endfunction

  // Present one request and hold it until it is taken; idle before it at random.
  task automatic send_request(input logic [3:0] op, input logic [2:0] ty,
                              input logic [63:0] a, input logic [63:0] b,
                              input logic [3:0] ct);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, ct, b, a, ty, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic send_random();
    logic [2:0] ty;
    ty = 3'($urandom_range(7));
    send_request(4'($urandom_range(15)), ty, pick_operand(ty), pick_operand(ty),
                 4'($urandom_range(15)));
  endtask

  initial begin
    int waited;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    out_tready = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: every operation, type edges, the undefined cases.
    for (int op = 0; op < 16; op++)
      send_request(op[3:0], op[2:0], 64'h8000_0000_0000_0080, '1, op[3:0]);
    send_request(OP_DIV, 3'd2, 64'h8000_0000, '1, 4'd0);          // signed min / -1
    send_request(OP_REM, 3'd3, 64'h8000_0000_0000_0000, '1, 4'd0);
    send_request(OP_DIV, 3'd4, 64'd77, 64'hFF00, 4'd0);           // zero at width
    send_request(OP_SHR, 3'd0, 64'h80, 64'd8, 4'd0);              // shift too large, sign fill
    send_request(OP_SHL, 3'd7, '1, 64'd63, 4'd0);
    send_request(OP_CAST, 3'd1, 64'h8001, 64'd0, CastPtr);
    send_request(OP_CAST, 3'd3, '1, 64'd0, 4'd10);                // float target unsupported
    send_request(OP_REM, 3'd1, 64'hFFF9, 64'd2, 4'd0);            // remainder takes dividend sign

    // Random phases: none, sender idle, receiver stall, both, then none again.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        3: begin send_idle_pct = 13; recv_stall_pct = 13; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int i = 0; i < 375; i++) send_random();
      if (ph == 2) begin
        // hold off until the pipeline has drained completely
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;
    recv_stall_pct = 0;

    waited = 0;
    while (pending != 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);

    $display("tb: %0d requests across all opcodes, types and cast targets,", sent);
    $display("tb: with sender gaps, receiver stalls and a full drain mid-run");
    if (fail_count == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
